FILE: src/lslh_pkg.sv
// Shared constants, codes and threshold function for the log-scale latency histogram.
// No dependencies; imported by lslh_bin_pick and log_scale_latency_histogram_unit.
package lslh_pkg;

    localparam int HALF_BINS = 10;
    localparam int STEP_BASE = 10;
    localparam int NUM_BINS  = 2 * HALF_BINS + 1;
    localparam int TOP_BIN   = 2 * HALF_BINS;
    localparam int IDX_W     = $clog2(NUM_BINS);
    localparam int K_W       = $clog2(HALF_BINS + 1);

    // Field widths
    localparam int BIN_W   = 5;
    localparam int COUNT_W = 32;
    localparam int SEC_W   = 32;
    localparam int NS_W    = 31;

    // Stream packing
    localparam int IN_FIELDS_W  = SEC_W + NS_W + BIN_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = BIN_W + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic
    {
        CMD_RECORD = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    // STEP_BASE raised to k; only ever evaluated at elaboration
    function automatic logic [63:0] step_limit(input int k);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = 0; i < k; i++)
        begin
            acc = acc * 64'(STEP_BASE);
        end
        return acc;
    endfunction

endpackage

FILE: src/lslh_bin_pick.sv
// Bin selection for one timing difference: sign of seconds, then decade of nanoseconds.
// Depends on lslh_pkg for bin counts and thresholds.
module lslh_bin_pick
(
    input  logic [lslh_pkg::SEC_W-1:0] diff_seconds,
    input  logic [lslh_pkg::NS_W-1:0]  diff_nanoseconds,
    output logic [lslh_pkg::IDX_W-1:0] bin
);
    import lslh_pkg::*;

    logic            ns_neg;
    logic [NS_W-1:0] mag;
    logic [HALF_BINS-1:0] below;
    logic            hit;
    logic [K_W-1:0]  k_sel;

    assign ns_neg = diff_nanoseconds[NS_W-1];
    assign mag    = ns_neg ? (~diff_nanoseconds + NS_W'(1)) : diff_nanoseconds;

    // Thresholds are constants, compared side by side
    for (genvar k = 1; k <= HALF_BINS; k++)
    begin : g_limit
        localparam logic [63:0] LIM = step_limit(k);
        assign below[k-1] = ({{(64 - NS_W){1'b0}}, mag} < LIM);
    end

    // Smallest k wins: scan downward so the lowest set flag is kept
    always_comb
    begin
        hit   = 1'b0;
        k_sel = '0;
        for (int k = HALF_BINS; k >= 1; k--)
        begin
            if (below[k-1])
            begin
                hit   = 1'b1;
                k_sel = K_W'(k);
            end
        end
    end

    always_comb
    begin
        if (diff_seconds != '0)
        begin
            bin = diff_seconds[SEC_W-1] ? '0 : IDX_W'(TOP_BIN);
        end
        else if (diff_nanoseconds == '0)
        begin
            bin = IDX_W'(HALF_BINS);
        end
        else if (!hit)
        begin
            // beyond every limit: outer bin on that side
            bin = ns_neg ? '0 : IDX_W'(TOP_BIN);
        end
        else if (ns_neg)
        begin
            bin = IDX_W'(HALF_BINS) - IDX_W'(k_sel);
        end
        else
        begin
            bin = IDX_W'(HALF_BINS) + IDX_W'(k_sel);
        end
    end

endmodule

FILE: src/log_scale_latency_histogram_unit.sv
// Log-scale latency histogram: input register, bin pick and count update, result register.
// Depends on lslh_pkg and lslh_bin_pick.
//
//  channel  | dir | tdata (low bit up)                                   | tuser
//  ---------+-----+------------------------------------------------------+---------
//  s_axis   | in  | diff_seconds[31:0], diff_nanoseconds[62:32],         | command
//           |     | read_bin[67:63], zero pad to 72                      |
//  m_axis   | out | bin_number[4:0], bin_count[36:5], zero pad to 40     | -
//
// One transaction per cycle sustained while m_axis_tready is high; a result passes through
// the input register, a single pass of bin pick, counter select and 32-bit increment, then
// the result register. Counters are flip-flops cleared at once by rst_n; no clearing pass
// is needed. A stalled result holds the result register, then the input register;
// s_axis_tready falls only while both are full and m_axis_tready is low.
module log_scale_latency_histogram_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // diff_seconds, diff_nanoseconds, read_bin, zero pad
    input  logic [lslh_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // bin_number, bin_count, zero pad
    output logic [lslh_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lslh_pkg::*;

    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    logic [SEC_W-1:0]    in_sec_reg;
    logic [NS_W-1:0]     in_ns_reg;
    logic [BIN_W-1:0]    in_rbin_reg;

    logic                out_valid_reg;
    logic [BIN_W-1:0]    out_bin_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [COUNT_W-1:0]  counts_reg [NUM_BINS];

    logic                advance;
    logic [IDX_W-1:0]    pick_idx;
    logic [IDX_W-1:0]    read_idx;
    logic [IDX_W-1:0]    sel_idx;
    logic [COUNT_W-1:0]  sel_count;
    logic [COUNT_W-1:0]  count_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg  <= cmd_t'(s_axis_tuser[0]);
            in_sec_reg  <= s_axis_tdata[SEC_W-1:0];
            in_ns_reg   <= s_axis_tdata[SEC_W+NS_W-1:SEC_W];
            in_rbin_reg <= s_axis_tdata[IN_FIELDS_W-1:SEC_W+NS_W];
        end
    end

    lslh_bin_pick u_bin_pick
    (
        .diff_seconds     (in_sec_reg),
        .diff_nanoseconds (in_ns_reg),
        .bin              (pick_idx)
    );

    // Clamp reads past the top bin
    assign read_idx  = (in_rbin_reg > BIN_W'(TOP_BIN)) ? IDX_W'(TOP_BIN)
                                                       : in_rbin_reg[IDX_W-1:0];
    assign sel_idx   = (in_cmd_reg == CMD_READ) ? read_idx : pick_idx;
    assign sel_count = counts_reg[sel_idx];

    always_comb
    begin
        case (in_cmd_reg)
            CMD_RECORD: count_next = (sel_count == '1) ? sel_count : sel_count + COUNT_W'(1);
            CMD_READ:   count_next = sel_count;
            default:    count_next = sel_count;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (advance && in_cmd_reg == CMD_RECORD)
        begin
            counts_reg[sel_idx] <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_bin_reg   <= BIN_W'(sel_idx);
            out_count_reg <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, out_count_reg, out_bin_reg};

    // A record below saturation leaves the chosen counter one higher
    a_record_inc: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_cmd_reg == CMD_RECORD && sel_count != '1
        |=> counts_reg[$past(sel_idx)] == $past(sel_count) + COUNT_W'(1))
        else $error("record did not increment its bin");

    // A read leaves the counter it names untouched
    a_read_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_cmd_reg == CMD_READ
        |=> counts_reg[$past(sel_idx)] == $past(sel_count))
        else $error("read changed a counter");

    // Back-pressure only when both registers are full and the output stalls
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // Result bin stays inside the histogram
    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_bin_reg <= BIN_W'(TOP_BIN))
        else $error("result bin out of range");

    // The result carries the value its counter holds after the transaction
    a_result_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_count_reg == counts_reg[out_bin_reg[IDX_W-1:0]])
        else $error("result count differs from stored count");

endmodule
